// ===== hw/rtl/led_link_packet_parser_macros.svh =====
// Assertion macros shared by the LED link packet parser RTL.
`ifndef LED_LINK_PACKET_PARSER_MACROS_SVH
`define LED_LINK_PACKET_PARSER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LLPP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("llpp assertion failed");

// Check a consequence in the same cycle as its trigger.
`define LLPP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llpp assertion failed");

// Check a consequence in the cycle after its trigger.
`define LLPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llpp assertion failed");

`endif

// ===== hw/rtl/llpp_pkg.sv =====
// Types, codes and constant tables of the LED link packet parser.
package llpp_pkg;

    localparam int unsigned HDR_LEN = 6;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = 2;
    localparam int unsigned QCNT_W  = 3;
    localparam int unsigned VER_LEN = 12;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [2:0] FT_UNLOCK  = 3'd0;
    localparam logic [2:0] FT_PROTO   = 3'd1;
    localparam logic [2:0] FT_COUNT   = 3'd2;
    localparam logic [2:0] FT_LEDDATA = 3'd3;
    localparam logic [2:0] FT_UNREC   = 3'd4;
    localparam logic [2:0] FT_RANGE   = 3'd5;

    localparam logic [1:0] KW_UNLOCK = 2'd0;
    localparam logic [1:0] KW_PROTO  = 2'd1;
    localparam logic [1:0] KW_LEDSC  = 2'd2;

    localparam logic [2:0] KW_LEN [3] = '{3'd6, 3'd5, 3'd5};

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    typedef struct packed {
        logic        has_pixel;
        logic [7:0]  pix_byte;
        logic [11:0] pix_idx;
        logic        has_event;
        logic [2:0]  ev_type;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic empty;
        t_cmd cmd;
    } t_qhead;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_EVENT,
        ST_VER,
        ST_HUND,
        ST_TENS,
        ST_ONES,
        ST_CR,
        ST_LF
    } t_step;

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case ({k, p})
            {KW_UNLOCK, 3'd0}: c = 8'h75;
            {KW_UNLOCK, 3'd1}: c = 8'h6E;
            {KW_UNLOCK, 3'd2}: c = 8'h6C;
            {KW_UNLOCK, 3'd3}: c = 8'h6F;
            {KW_UNLOCK, 3'd4}: c = 8'h63;
            {KW_UNLOCK, 3'd5}: c = 8'h6B;
            {KW_PROTO,  3'd0}: c = 8'h70;
            {KW_PROTO,  3'd1}: c = 8'h72;
            {KW_PROTO,  3'd2}: c = 8'h6F;
            {KW_PROTO,  3'd3}: c = 8'h74;
            {KW_PROTO,  3'd4}: c = 8'h6F;
            {KW_LEDSC,  3'd0}: c = 8'h6C;
            {KW_LEDSC,  3'd1}: c = 8'h65;
            {KW_LEDSC,  3'd2}: c = 8'h64;
            {KW_LEDSC,  3'd3}: c = 8'h73;
            {KW_LEDSC,  3'd4}: c = 8'h63;
            default:           c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] footer_byte(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = 8'hFF;
            2'd1:    c = 8'hFE;
            default: c = 8'hFD;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h49;
            4'd2:    c = 8'h4D;
            4'd3:    c = 8'h48;
            4'd4:    c = 8'h55;
            4'd5:    c = 8'h42;
            4'd6:    c = 8'h5F;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h2E;
            4'd9:    c = 8'h30;
            4'd10:   c = 8'h0D;
            4'd11:   c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/llpp_front.sv =====
// Front end: configuration register, frame tracking and byte classification.
module llpp_front #(
    parameter int MAX_PIXELS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_cfg_we,
    input  logic [9:0]      i_cfg_data,
    input  logic            i_q_full,
    output llpp_pkg::t_push o_push,
    output logic [9:0]      o_pixel_count
);
    import llpp_pkg::*;

    logic [9:0]  r_pixel_count;
    logic [11:0] r_plen;
    logic [11:0] r_pos, n_pos;
    logic [2:0]  r_alive, n_alive;
    logic        r_fok, n_fok;

    logic        accept;
    logic [11:0] off;
    logic [12:0] off_w;
    logic [12:0] plen_w;
    logic [2:0]  alive;
    logic        done;
    logic [1:0]  done_k;
    logic        fok;
    logic        in_payload;
    logic        over_range;
    t_push       push;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_ready = !i_q_full;
    assign off        = r_pos - 12'(HDR_LEN);
    assign off_w      = {1'b0, off};
    assign plen_w     = {1'b0, r_plen};
    assign in_payload = off_w < plen_w;
    assign over_range = {22'd0, r_pixel_count} > 32'(MAX_PIXELS);

    always_comb begin
        alive  = r_alive;
        done   = 1'b0;
        done_k = KW_UNLOCK;
        for (int k = 0; k < 3; k++) begin
            if (r_alive[k]) begin
                if (off < {9'd0, KW_LEN[k]} && i_rx_byte == kw_char(2'(k), off[2:0])) begin
                    if (off == {9'd0, KW_LEN[k]} - 12'd1) begin
                        done   = 1'b1;
                        done_k = 2'(k);
                    end
                end else begin
                    alive[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        fok = r_fok;
        if (in_payload) begin
            fok = r_fok;
        end else if (off_w < plen_w + 13'd3) begin
            if (r_fok && i_rx_byte != footer_byte(2'(off_w - plen_w))) begin
                fok = 1'b0;
            end
        end else begin
            fok = 1'b0;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_alive = r_alive;
        n_fok   = r_fok;
        push    = '0;
        if (accept) begin
            if (r_pos < 12'(HDR_LEN)) begin
                n_pos = r_pos + 12'd1;
            end else if (done) begin
                push.cmd.has_event = 1'b1;
                unique case (done_k)
                    KW_UNLOCK: push.cmd.ev_type = FT_UNLOCK;
                    KW_PROTO:  push.cmd.ev_type = FT_PROTO;
                    default:   push.cmd.ev_type = over_range ? FT_RANGE : FT_COUNT;
                endcase
                n_pos   = '0;
                n_alive = 3'b111;
                n_fok   = 1'b1;
            end else begin
                push.cmd.has_pixel = in_payload;
                push.cmd.pix_byte  = i_rx_byte;
                push.cmd.pix_idx   = off;
                if (fok && off_w == plen_w + 13'd2) begin
                    push.cmd.has_event = 1'b1;
                    push.cmd.ev_type   = FT_LEDDATA;
                    n_pos   = '0;
                    n_alive = 3'b111;
                    n_fok   = 1'b1;
                end else if (alive == 3'b000 && !fok) begin
                    push.cmd.has_event = 1'b1;
                    push.cmd.ev_type   = FT_UNREC;
                    n_pos   = '0;
                    n_alive = 3'b111;
                    n_fok   = 1'b1;
                end else begin
                    n_pos   = r_pos + 12'd1;
                    n_alive = alive;
                    n_fok   = fok;
                end
            end
            push.push = push.cmd.has_pixel || push.cmd.has_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= '0;
            r_plen        <= '0;
            r_pos         <= '0;
            r_alive       <= 3'b111;
            r_fok         <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_pixel_count <= i_cfg_data;
                r_plen        <= {1'b0, i_cfg_data, 1'b0} + {2'b00, i_cfg_data};
            end
            r_pos   <= n_pos;
            r_alive <= n_alive;
            r_fok   <= n_fok;
        end
    end

    assign o_push        = push;
    assign o_pixel_count = r_pixel_count;

endmodule

// ===== hw/rtl/llpp_queue.sv =====
// Command queue between the front end and the result sequencer.
module llpp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  llpp_pkg::t_push  i_push,
    output logic             o_full,
    input  logic             i_pop,
    output llpp_pkg::t_qhead o_head
);
    import llpp_pkg::*;

    `include "led_link_packet_parser_macros.svh"

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full       = r_cnt == QCNT_W'(QDEPTH);
    assign o_head.empty = r_cnt == '0;
    assign o_head.cmd   = r_mem[r_rp];
    assign do_pop       = i_pop && !o_head.empty;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push.push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push.push && do_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    `LLPP_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= QCNT_W'(QDEPTH))
    `LLPP_ASSERT_ALWAYS(a_no_push_full, i_clk, i_rst_n, !(i_push.push && o_full))
    `LLPP_ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && o_head.empty))
    `LLPP_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, i_push.push && !i_pop, r_cnt == $past(r_cnt) + QCNT_W'(1))

endmodule

// ===== hw/rtl/llpp_back.sv =====
// Result sequencer: expands queued commands into result transactions.
module llpp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  llpp_pkg::t_qhead i_head,
    output logic             o_pop,
    input  logic [9:0]       i_pixel_count,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [11:0]      o_pixel_byte_index,
    output logic [2:0]       o_frame_type,
    output logic             o_last
);
    import llpp_pkg::*;

    `include "led_link_packet_parser_macros.svh"

    t_step       r_st, n_st;
    t_cmd        r_cmd;
    logic [3:0]  r_ver_idx;
    logic [3:0]  r_hund;
    logic [6:0]  r_rem;
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_byte;
    logic [11:0] r_out_idx;
    logic [2:0]  r_out_type;
    logic        r_out_last;

    logic        out_free;
    logic        emit;
    logic        advance;
    logic [1:0]  e_kind;
    logic [7:0]  e_byte;
    logic [11:0] e_idx;
    logic [2:0]  e_type;
    logic        e_last;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [3:0]  hund_calc;
    logic [6:0]  rem_calc;

    assign out_free  = !r_out_valid || i_out_ready;
    assign advance   = !emit || out_free;
    assign hund_calc = 4'(({6'd0, i_pixel_count} * 16'd41) >> 12);
    assign rem_calc  = 7'(i_pixel_count - 10'({6'd0, r_hund} * 10'd100));

    always_comb begin
        tens = 4'd0;
        for (int j = 1; j < 10; j++) begin
            if (r_rem >= 7'(10 * j)) begin
                tens = 4'(j);
            end
        end
        ones = 4'(r_rem - 7'({3'd0, tens} * 7'd10));
    end

    always_comb begin
        emit   = 1'b0;
        e_kind = KIND_REPLY;
        e_byte = 8'h00;
        e_idx  = '0;
        e_type = FT_UNLOCK;
        e_last = 1'b0;
        o_pop  = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                o_pop = !i_head.empty;
            end
            ST_PIXEL: begin
                emit   = 1'b1;
                e_kind = KIND_PIXEL;
                e_byte = r_cmd.pix_byte;
                e_idx  = r_cmd.pix_idx;
                e_last = !r_cmd.has_event;
            end
            ST_EVENT: begin
                emit   = 1'b1;
                e_kind = KIND_EVENT;
                e_type = r_cmd.ev_type;
                e_last = !(r_cmd.ev_type == FT_PROTO || r_cmd.ev_type == FT_COUNT);
            end
            ST_VER: begin
                emit   = 1'b1;
                e_byte = ver_char(r_ver_idx);
                e_last = r_ver_idx == 4'(VER_LEN - 1);
            end
            ST_HUND: begin
                emit   = r_hund != 4'd0;
                e_byte = CHAR_ZERO + {4'd0, r_hund};
            end
            ST_TENS: begin
                emit   = r_hund != 4'd0 || tens != 4'd0;
                e_byte = CHAR_ZERO + {4'd0, tens};
            end
            ST_ONES: begin
                emit   = 1'b1;
                e_byte = CHAR_ZERO + {4'd0, ones};
            end
            ST_CR: begin
                emit   = 1'b1;
                e_byte = CHAR_CR;
            end
            ST_LF: begin
                emit   = 1'b1;
                e_byte = CHAR_LF;
                e_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (!i_head.empty) begin
                    n_st = i_head.cmd.has_pixel ? ST_PIXEL : ST_EVENT;
                end
            end
            ST_PIXEL: begin
                if (advance) begin
                    n_st = r_cmd.has_event ? ST_EVENT : ST_IDLE;
                end
            end
            ST_EVENT: begin
                if (advance) begin
                    if (r_cmd.ev_type == FT_PROTO) begin
                        n_st = ST_VER;
                    end else if (r_cmd.ev_type == FT_COUNT) begin
                        n_st = ST_HUND;
                    end else begin
                        n_st = ST_IDLE;
                    end
                end
            end
            ST_VER: begin
                if (advance && r_ver_idx == 4'(VER_LEN - 1)) begin
                    n_st = ST_IDLE;
                end
            end
            ST_HUND: if (advance) n_st = ST_TENS;
            ST_TENS: if (advance) n_st = ST_ONES;
            ST_ONES: if (advance) n_st = ST_CR;
            ST_CR:   if (advance) n_st = ST_LF;
            ST_LF:   if (advance) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd     <= i_head.cmd;
            r_ver_idx <= '0;
            r_hund    <= hund_calc;
        end
        if (r_st == ST_VER && advance) begin
            r_ver_idx <= r_ver_idx + 4'd1;
        end
        if (r_st == ST_HUND && advance) begin
            r_rem <= rem_calc;
        end
        if (emit && out_free) begin
            r_out_kind <= e_kind;
            r_out_byte <= e_byte;
            r_out_idx  <= e_idx;
            r_out_type <= e_type;
            r_out_last <= e_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_out_kind;
    assign o_byte_value       = r_out_byte;
    assign o_pixel_byte_index = r_out_idx;
    assign o_frame_type       = r_out_type;
    assign o_last             = r_out_last;

    `LLPP_ASSERT_IMPLY(a_tail_pending, i_clk, i_rst_n, r_out_valid && !r_out_last, r_st != ST_IDLE)
    `LLPP_ASSERT_IMPLY(a_pixel_type, i_clk, i_rst_n, r_out_valid && r_out_kind == KIND_PIXEL, r_out_type == FT_UNLOCK)
    `LLPP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_byte) && $stable(r_out_kind))

endmodule

// ===== hw/rtl/led_link_packet_parser.sv =====
// LED link packet parser top level.
//
// Input channel: i_in_valid / o_in_ready carry one received byte (i_rx_byte)
// per transaction. Output channel: o_out_valid / i_out_ready carry one result
// per transaction (o_kind, o_byte_value, o_pixel_byte_index, o_frame_type,
// o_last); o_last marks the final result caused by one input byte.
// Configuration: i_cfg_we writes i_cfg_data into the pixel count register.
// Each input byte is classified combinationally by the front end and, if it
// causes results, turned into one command for a four-entry queue. The
// sequencer emits one result per cycle while the receiver does not stall;
// each command is first loaded in its idle state, and a count reply always
// steps through all three digit positions. Commands pass the queue and the
// sequencer command register; results leave via an output register. One byte
// per cycle enters the queue while not full; a version reply is 13 results.
// Reset clears the pixel count to zero and starts a new frame.
// When the receiver stalls, the current result holds; the queue then fills
// and o_in_ready drops until the sequencer drains an entry.
module led_link_packet_parser #(
    parameter int MAX_PIXELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [11:0] o_pixel_byte_index,
    output logic [2:0]  o_frame_type,
    output logic        o_last
);
    import llpp_pkg::*;

    t_push      push;
    t_qhead     head;
    logic       q_full;
    logic       pop;
    logic [9:0] pixel_count;

    llpp_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_pixel_count(pixel_count)
    );

    llpp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (q_full),
        .i_pop  (pop),
        .o_head (head)
    );

    llpp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_pop             (pop),
        .i_pixel_count     (pixel_count),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_byte_value      (o_byte_value),
        .o_pixel_byte_index(o_pixel_byte_index),
        .o_frame_type      (o_frame_type),
        .o_last            (o_last)
    );

endmodule

// ===== dv/llpp_check_pkg.sv =====
// Scoreboard for the LED link packet parser: frame predictor and result checks.
package llpp_check_pkg;
    import llpp_pkg::*;

    localparam int HEADER_BYTES = 6;
    localparam int PIXEL_LIMIT  = 64;
    localparam int REPORT_CAP   = 40;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [11:0] pix_index;
        logic [2:0]  frame_type;
        logic        last;
    } parser_result_t;

    class parser_scoreboard;
        parser_result_t pending_results[$];
        logic [9:0]     led_count;
        logic [11:0]    frame_pos;
        logic [2:0]     kw_live;
        logic           footer_live;
        int             errors;
        int             checked;
        string          kw_text[3];
        logic [7:0]     footer_seq[3];
        logic [7:0]     version_reply[12];

        function new();
            kw_text       = '{"unlock", "proto", "ledsc"};
            footer_seq    = '{8'hFF, 8'hFE, 8'hFD};
            version_reply = '{8'h53, 8'h49, 8'h4D, 8'h48, 8'h55, 8'h42,
                              8'h5F, 8'h31, 8'h2E, 8'h30, CHAR_CR, CHAR_LF};
            led_count = '0;
            errors    = 0;
            checked   = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            frame_pos   = '0;
            kw_live     = 3'b111;
            footer_live = 1'b1;
        endfunction

        function bit in_header();
            return frame_pos < HEADER_BYTES;
        endfunction

        function bit at_frame_start();
            return frame_pos == 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] val, logic [11:0] idx,
                                  logic [2:0] ftype);
            parser_result_t r;
            r.kind       = kind;
            r.byte_value = val;
            r.pix_index  = idx;
            r.frame_type = ftype;
            r.last       = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void push_count_reply();
            string digits;
            int    i;
            if (led_count > PIXEL_LIMIT) begin
                push_result(KIND_EVENT, '0, '0, FT_RANGE);
                return;
            end
            push_result(KIND_EVENT, '0, '0, FT_COUNT);
            digits = $sformatf("%0d", led_count);
            for (i = 0; i < digits.len(); i++)
                push_result(KIND_REPLY, digits[i], '0, '0);
            push_result(KIND_REPLY, CHAR_CR, '0, '0);
            push_result(KIND_REPLY, CHAR_LF, '0, '0);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            int             off;
            int             plen;
            int             k;
            int             done;
            int             before_n;
            logic [2:0]     live;
            parser_result_t tail;
            before_n = pending_results.size();
            if (frame_pos < HEADER_BYTES) begin
                frame_pos = frame_pos + 12'd1;
                return;
            end
            off  = int'(frame_pos) - HEADER_BYTES;
            live = kw_live;
            done = -1;
            for (k = 0; k < 3; k++) begin
                if (live[k]) begin
                    if (off < kw_text[k].len() && b == kw_text[k][off]) begin
                        if (off == kw_text[k].len() - 1)
                            done = k;
                    end else begin
                        live[k] = 1'b0;
                    end
                end
            end
            if (done >= 0) begin
                case (done)
                    int'(KW_UNLOCK): push_result(KIND_EVENT, '0, '0, FT_UNLOCK);
                    int'(KW_PROTO): begin
                        push_result(KIND_EVENT, '0, '0, FT_PROTO);
                        for (k = 0; k < 12; k++)
                            push_result(KIND_REPLY, version_reply[k], '0, '0);
                    end
                    default: push_count_reply();
                endcase
                restart_frame();
            end else begin
                plen = 3 * int'(led_count);
                if (off < plen) begin
                    push_result(KIND_PIXEL, b, 12'(off), '0);
                end else if (off < plen + 3) begin
                    if (footer_live && b != footer_seq[off - plen])
                        footer_live = 1'b0;
                end else begin
                    footer_live = 1'b0;
                end
                if (footer_live && off == plen + 2) begin
                    push_result(KIND_EVENT, '0, '0, FT_LEDDATA);
                    restart_frame();
                end else if (live == 3'b000 && !footer_live) begin
                    push_result(KIND_EVENT, '0, '0, FT_UNREC);
                    restart_frame();
                end else begin
                    frame_pos = frame_pos + 12'd1;
                    kw_live   = live;
                end
            end
            if (pending_results.size() > before_n) begin
                tail      = pending_results.pop_back();
                tail.last = 1'b1;
                pending_results.push_back(tail);
            end
        endfunction

        task flag(string what);
            if (errors < REPORT_CAP)
                $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                flag($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
        endtask

        task check_result(parser_result_t got);
            parser_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                flag($sformatf("result %0d unexpected: kind %0d value %02h type %0d",
                               checked, got.kind, got.byte_value, got.frame_type));
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("byte_value", got.byte_value, want.byte_value);
            compare_field("pixel_byte_index", got.pix_index, want.pix_index);
            compare_field("frame_type", got.frame_type, want.frame_type);
            compare_field("last", got.last, want.last);
        endtask

        task report_leftovers();
            parser_result_t want;
            while (pending_results.size() != 0) begin
                want = pending_results.pop_front();
                flag($sformatf("missing result: kind %0d value %02h index %0d type %0d",
                               want.kind, want.byte_value, want.pix_index, want.frame_type));
            end
        endtask
    endclass

endpackage

// ===== dv/led_link_packet_parser_test.sv =====
// Self-checking testbench for the LED link packet parser.
module led_link_packet_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import llpp_pkg::*;
    import llpp_check_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = '0;
    logic        cfg_we    = 1'b0;
    logic [9:0]  cfg_data  = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [11:0] pix_index;
    logic [2:0]  frame_type;
    logic        last;

    parser_scoreboard sb = new();
    parser_result_t   seen;
    int               quiet       = 0;
    int               bytes_sent  = 0;
    int               payload_sent = 0;
    int               counts_used = 0;
    int               cur_count   = 0;
    bit               in_rush     = 1'b0;
    bit               out_rush    = 1'b0;
    string            keywords[3] = '{"unlock", "proto", "ledsc"};
    logic [7:0]       footer_seq[3] = '{8'hFF, 8'hFE, 8'hFD};

    led_link_packet_parser #(
        .MAX_PIXELS(PIXEL_LIMIT)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_rx_byte          (rx_byte),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_kind             (kind),
        .o_byte_value       (byte_value),
        .o_pixel_byte_index (pix_index),
        .o_frame_type       (frame_type),
        .o_last             (last)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int draw_idle(bit rush);
        return rush ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_idle(in_rush);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (!sb.in_header())
            payload_sent++;
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header();
        repeat (HEADER_BYTES) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_led_frame(input bit spoil);
        int i;
        int bad_at;
        send_header();
        for (i = 0; i < 3 * cur_count; i++)
            send_byte(8'($urandom_range(0, 255)));
        bad_at = spoil ? $urandom_range(0, 2) : 3;
        for (i = 0; i < 3; i++)
            send_byte(i == bad_at ? footer_seq[i] ^ (8'h01 << $urandom_range(0, 7))
                                  : footer_seq[i]);
    endtask

    task automatic send_keyword(input int k, input bit spoil);
        int         i;
        int         bad_at;
        logic [7:0] c;
        send_header();
        bad_at = spoil ? $urandom_range(0, keywords[k].len() - 1) : keywords[k].len();
        for (i = 0; i < keywords[k].len(); i++) begin
            c = keywords[k][i];
            send_byte(i == bad_at ? c ^ (8'h01 << $urandom_range(0, 7)) : c);
        end
    endtask

    // Drain a broken frame until the parser restarts.
    task automatic resync();
        while (!sb.at_frame_start())
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        string alphabet;
        int    n;
        alphabet = "unlockprotedsc";
        n = $urandom_range(1, 10);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                send_byte(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 3) == 0)
                send_byte(footer_seq[$urandom_range(0, 2)]);
            else
                send_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
    endtask

    task automatic run_mix(input int budget);
        int start;
        int pick;
        start = payload_sent;
        while (payload_sent - start < budget) begin
            resync();
            in_rush = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_led_frame($urandom_range(0, 3) == 0);
            else if (pick < 8)
                send_keyword($urandom_range(0, 2), $urandom_range(0, 3) == 0);
            else
                send_noise();
        end
        resync();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input logic [9:0] v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.led_count = v;
        cur_count    = v;
        counts_used++;
    endtask

    // Receiver: random stall before each result.
    initial begin
        int stall;
        int served;
        served = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (served % 32 == 0)
                out_rush = ($urandom_range(0, 2) == 0);
            stall = draw_idle(out_rush);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            served++;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                seen.kind       = kind;
                seen.byte_value = byte_value;
                seen.pix_index  = pix_index;
                seen.frame_type = frame_type;
                seen.last       = last;
                sb.check_result(seen);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("led_link_packet_parser verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset pixel count of zero.
        send_header();
        send_text("unlock");
        send_header();
        send_text("proto");
        send_header();
        send_text("ledsc");
        send_led_frame(1'b0);
        send_header();
        send_byte(8'h80);

        // Lower the pixel count mid-frame so the frame runs past its end.
        set_count(10'd2);
        send_header();
        repeat (5) send_byte(8'h00);
        set_count(10'd0);
        send_byte(8'h00);

        set_count(10'd1);
        run_mix(10);
        set_count(10'd3);
        run_mix(10);
        set_count(10'd9);
        run_mix(10);

        set_count(10'd64);
        send_keyword(int'(KW_LEDSC), 1'b0);
        set_count(10'd65);
        send_keyword(int'(KW_LEDSC), 1'b0);
        set_count(10'd999);
        send_keyword(int'(KW_LEDSC), 1'b0);
        send_keyword(int'(KW_UNLOCK), 1'b0);

        set_count(10'($urandom_range(0, 12)));
        run_mix(10);

        drain_results();
        sb.report_leftovers();
        $display("Run covered %0d received bytes (%0d past the header) over %0d pixel counts.",
                 bytes_sent, payload_sent, counts_used);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("led_link_packet_parser verification clean");
        else
            $display("led_link_packet_parser verification failed");
        $finish;
    end

endmodule
